// ===== rtl/core/lsbfr_pkg.sv =====
// Package for the LSB-first bit field reader: sizes, status codes and beat layouts.
// No dependencies; imported by rtl/core/lsb_first_bit_field_reader.sv.
package lsbfr_pkg;

  localparam int MAX_FIELD_BITS = 32;
  localparam int BUFFER_BITS    = 64;
  localparam int BYTE_BITS      = 8;

  localparam int IN_DATA_BITS   = 16;
  localparam int OUT_DATA_BITS  = 48;

  // Item kind carried in in_tuser
  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_READ = 1'b1
  } kind_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_UNDERRUN = 2'd1,
    ST_DROPPED  = 2'd2
  } status_t;

endpackage

// ===== rtl/core/lsb_first_bit_field_reader.sv =====
// Top level of the LSB-first bit field reader: input beat register, combinational
// field extraction and a result register. Depends on rtl/core/lsbfr_pkg.sv.
//
//   channel | dir | tdata (low bit up)                                  | tuser
//   in_     | in  | byte_in[7:0] field_bits[13:8] first_piece_high[14]  | kind[0]
//   out_    | out | value[31:0] status[33:32] bits_held[40:34]          | -
//
// One result beat per input beat; a beat passes through the input register and then the result
// register, and a new beat is taken every cycle while the result channel is not stalled.
// The extraction (mask, byte-piece reorder, buffer shift) is one combinational
// pass from the input register into the result register and the bit buffer.
// Reset (rst_n low, synchronous) empties both registers and clears the buffer.
// A stalled out_tready holds the result; the input register still takes one beat.
module lsb_first_bit_field_reader
  import lsbfr_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  logic [IN_DATA_BITS-1:0]  in_tdata,   // byte_in, field_bits, first_piece_high
  input  logic                     in_tuser,   // kind
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [OUT_DATA_BITS-1:0] out_tdata   // value, status, bits_held
);

  // input beat register
  logic        a_valid_r;
  kind_t       a_kind_r;
  logic [7:0]  a_byte_r;
  logic [5:0]  a_nbits_r;
  logic        a_high_r;

  // reader state
  logic [BUFFER_BITS-1:0] buf_r,   buf_nxt;
  logic [6:0]             held_r,  held_nxt;
  logic [2:0]             phase_r, phase_nxt;

  // result register
  logic        out_valid_r;
  logic [31:0] value_r,  value_nxt;
  status_t     status_r, status_nxt;

  logic        advance;
  logic        in_fire;

  // extraction terms
  logic [5:0]  n;
  logic [31:0] field;
  logic [32:0] field_mask;
  logic [3:0]  room;
  logic [3:0]  first_len;
  logic [31:0] first_piece;
  logic [5:0]  rest_len;
  logic [1:0]  rest_bytes;
  logic [2:0]  rest_rem;
  logic [31:0] rest;
  logic [31:0] rest_rev;
  logic [31:0] rest_tail;
  logic [7:0]  tail_mask;
  logic [31:0] high_value;

  assign advance   = a_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !a_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, held_r, status_r, value_r};

  // saturate the read length and cut the field into byte pieces
  always_comb begin
    n = (a_nbits_r > 6'(MAX_FIELD_BITS)) ? 6'(MAX_FIELD_BITS) : a_nbits_r;
    field_mask = (33'd1 << n) - 33'd1;
    field = buf_r[31:0] & field_mask[31:0];

    room      = 4'd8 - {1'b0, phase_r};
    first_len = ({2'b00, room} > n) ? n[3:0] : room;
    first_piece = field & ((32'd1 << first_len) - 32'd1);

    rest_len   = n - {2'b00, first_len};
    rest_bytes = rest_len[4:3];
    rest_rem   = rest_len[2:0];
    rest       = field >> first_len;

    // reverse the whole bytes after the first piece
    case (rest_bytes)
      2'd0:    rest_rev = 32'd0;
      2'd1:    rest_rev = {24'd0, rest[7:0]};
      2'd2:    rest_rev = {16'd0, rest[7:0], rest[15:8]};
      default: rest_rev = {8'd0, rest[7:0], rest[15:8], rest[23:16]};
    endcase

    tail_mask  = 8'((9'd1 << rest_rem) - 9'd1);
    rest_tail  = (rest >> {rest_bytes, 3'b000}) & {24'd0, tail_mask};
    high_value = (first_piece << rest_len) | (rest_rev << rest_rem) | rest_tail;
  end

  // next state and result for the beat in the input register
  always_comb begin
    buf_nxt    = buf_r;
    held_nxt   = held_r;
    phase_nxt  = phase_r;
    value_nxt  = 32'd0;
    status_nxt = ST_OK;
    case (a_kind_r)
      KIND_LOAD: begin
        if (held_r > 7'(BUFFER_BITS - BYTE_BITS)) begin
          status_nxt = ST_DROPPED;
        end else begin
          buf_nxt  = buf_r | ({{(BUFFER_BITS-8){1'b0}}, a_byte_r} << held_r);
          held_nxt = held_r + 7'd8;
        end
      end
      KIND_READ: begin
        if ({1'b0, n} > held_r) begin
          status_nxt = ST_UNDERRUN;
        end else if (n != 6'd0) begin
          value_nxt = a_high_r ? high_value : field;
          buf_nxt   = buf_r >> n;
          held_nxt  = held_r - {1'b0, n};
          phase_nxt = phase_r + n[2:0];
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  // hold the input beat until it moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_fire) begin
      a_valid_r <= 1'b1;
    end else if (advance) begin
      a_valid_r <= 1'b0;
    end
    if (in_fire) begin
      a_kind_r  <= kind_t'(in_tuser);
      a_byte_r  <= in_tdata[7:0];
      a_nbits_r <= in_tdata[13:8];
      a_high_r  <= in_tdata[14];
    end
  end

  // advance the reader state and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      buf_r       <= '0;
      held_r      <= 7'd0;
      phase_r     <= 3'd0;
    end else begin
      if (advance) begin
        out_valid_r <= 1'b1;
        buf_r       <= buf_nxt;
        held_r      <= held_nxt;
        phase_r     <= phase_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (advance) begin
      value_r  <= value_nxt;
      status_r <= status_nxt;
    end
  end

  // held count never exceeds the buffer
  a_held_range: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= 7'(BUFFER_BITS))
    else $error("held count above buffer size");

  // front bit phase and held count always end on a byte boundary together
  a_phase_align: assert property (@(posedge clk) disable iff (!rst_n)
    ((held_r[2:0] + phase_r) & 3'd7) == 3'd0)
    else $error("phase and held count out of step");

  // bits above the held count are zero, so a load may OR its byte in
  a_buf_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (buf_r >> held_r) == '0)
    else $error("stale bits above held count");

  // a refused or dropped beat carries a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r != ST_OK) |-> value_r == 32'd0)
    else $error("nonzero value on error status");

  // a result that waits is not overwritten
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (out_valid_r && $stable(out_tdata)))
    else $error("waiting result changed");

endmodule

// ===== sim/tb_lsb_first_bit_field_reader.sv =====
// Testbench for lsb_first_bit_field_reader: directed table, then biased random beats. Typed rows
// use table results, the rest an in-bench bit queue predictor. Depends on rtl/core/lsbfr_pkg.sv.
module tb_lsb_first_bit_field_reader
  import lsbfr_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BEATS = 1425;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    kind_t       kind;
    logic [7:0]  byte_in;
    logic [5:0]  field_bits;
    logic        first_high;
    logic        typed;
    logic [31:0] value;
    status_t     status;
    logic [6:0]  held;
  } stim_row_t;

  typedef struct {
    logic [31:0] value;
    status_t     status;
    logic [6:0]  held;
  } field_result_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [IN_DATA_BITS-1:0]  in_tdata = '0;  // byte_in[7:0], field_bits[13:8], first_piece_high[14]
  logic                     in_tuser = 1'b0; // kind[0]
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] out_tdata;     // value[31:0], status[33:32], bits_held[40:34]

  // Predictor state: unread bits with the front of the stream at bit 0
  logic [63:0]     bit_queue = '0;
  int unsigned     held_count = 0;
  int unsigned     byte_phase = 0;

  field_result_t   field_results_due[$];
  int unsigned     mismatches = 0;
  int unsigned     cycle_count = 0;
  int unsigned     burst_left = 0;

  // Directed rows: reset state, empty and full buffer, saturation, both piece orders
  stim_row_t directed_rows [25] = '{
    '{KIND_READ, 8'h00, 6'd1,  1'b0, 1'b1, 32'h0, ST_UNDERRUN, 7'd0},
    '{KIND_READ, 8'hFF, 6'd0,  1'b1, 1'b1, 32'h0, ST_OK,       7'd0},
    '{KIND_READ, 8'h00, 6'd63, 1'b0, 1'b1, 32'h0, ST_UNDERRUN, 7'd0},
    '{KIND_LOAD, 8'hFF, 6'd63, 1'b1, 1'b1, 32'h0, ST_OK,       7'd8},
    '{KIND_LOAD, 8'h00, 6'd0,  1'b0, 1'b1, 32'h0, ST_OK,       7'd16},
    '{KIND_LOAD, 8'hA5, 6'd5,  1'b0, 1'b1, 32'h0, ST_OK,       7'd24},
    '{KIND_LOAD, 8'h3C, 6'd9,  1'b1, 1'b1, 32'h0, ST_OK,       7'd32},
    '{KIND_LOAD, 8'h81, 6'd0,  1'b0, 1'b1, 32'h0, ST_OK,       7'd40},
    '{KIND_LOAD, 8'h7E, 6'd32, 1'b1, 1'b1, 32'h0, ST_OK,       7'd48},
    '{KIND_LOAD, 8'hC3, 6'd1,  1'b0, 1'b1, 32'h0, ST_OK,       7'd56},
    '{KIND_LOAD, 8'h5A, 6'd2,  1'b0, 1'b1, 32'h0, ST_OK,       7'd64},
    '{KIND_LOAD, 8'h55, 6'd3,  1'b1, 1'b1, 32'h0, ST_DROPPED,  7'd64},
    '{KIND_READ, 8'hFF, 6'd3,  1'b0, 1'b0, 32'h0, ST_OK,       7'd0},
    '{KIND_READ, 8'h00, 6'd12, 1'b1, 1'b0, 32'h0, ST_OK,       7'd0},
    '{KIND_READ, 8'hFF, 6'd40, 1'b1, 1'b0, 32'h0, ST_OK,       7'd0},
    '{KIND_READ, 8'h00, 6'd33, 1'b0, 1'b1, 32'h0, ST_UNDERRUN, 7'd17},
    '{KIND_READ, 8'hFF, 6'd17, 1'b1, 1'b0, 32'h0, ST_OK,       7'd0},
    '{KIND_LOAD, 8'hFF, 6'd0,  1'b0, 1'b1, 32'h0, ST_OK,       7'd8},
    '{KIND_LOAD, 8'hFF, 6'd0,  1'b0, 1'b1, 32'h0, ST_OK,       7'd16},
    '{KIND_LOAD, 8'hFF, 6'd0,  1'b0, 1'b1, 32'h0, ST_OK,       7'd24},
    '{KIND_LOAD, 8'hFF, 6'd0,  1'b0, 1'b1, 32'h0, ST_OK,       7'd32},
    '{KIND_READ, 8'h00, 6'd32, 1'b0, 1'b1, 32'hFFFF_FFFF, ST_OK, 7'd0},
    '{KIND_LOAD, 8'h80, 6'd0,  1'b0, 1'b1, 32'h0, ST_OK,       7'd8},
    '{KIND_READ, 8'h00, 6'd8,  1'b1, 1'b0, 32'h0, ST_OK,       7'd0},
    '{KIND_READ, 8'h00, 6'd0,  1'b0, 1'b1, 32'h0, ST_OK,       7'd0}
  };

  lsb_first_bit_field_reader u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Advance the bit queue by one beat and return the result it produces
  function automatic field_result_t step_bit_queue(input stim_row_t row);
    field_result_t res;
    int unsigned   nbits;
    int unsigned   pos;
    int unsigned   len;
    int unsigned   room;
    logic [63:0]   acc;
    logic [63:0]   piece;
    res.value  = '0;
    res.status = ST_OK;
    acc        = '0;
    if (row.kind == KIND_LOAD) begin
      if (held_count + BYTE_BITS > BUFFER_BITS) begin
        res.status = ST_DROPPED;
      end else begin
        bit_queue  = bit_queue | ({56'd0, row.byte_in} << held_count);
        held_count = held_count + BYTE_BITS;
      end
    end else begin
      nbits = row.field_bits;
      if (nbits > MAX_FIELD_BITS) nbits = MAX_FIELD_BITS;
      if (nbits > held_count) begin
        res.status = ST_UNDERRUN;
      end else if (nbits > 0) begin
        // Cut the field at stream byte boundaries and stack the pieces
        pos  = 0;
        room = BYTE_BITS - byte_phase;
        while (pos < nbits) begin
          len = nbits - pos;
          if (len > room) len = room;
          piece = (bit_queue >> pos) & ((64'd1 << len) - 64'd1);
          if (row.first_high) acc = (acc << len) | piece;
          else acc = acc | (piece << pos);
          pos  = pos + len;
          room = BYTE_BITS;
        end
        bit_queue  = bit_queue >> nbits;
        held_count = held_count - nbits;
        byte_phase = (byte_phase + nbits) & 7;
      end
    end
    res.value = acc[31:0];
    res.held  = held_count[6:0];
    return res;
  endfunction

  // Pick a beat that keeps the buffer mostly between empty and full
  function automatic stim_row_t random_row();
    stim_row_t   row;
    int unsigned load_pct;
    int unsigned roll;
    row.typed      = 1'b0;
    row.value      = '0;
    row.status     = ST_OK;
    row.held       = '0;
    row.byte_in    = 8'($urandom_range(0, 255));
    row.first_high = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < 8) begin
      row.kind       = kind_t'($urandom_range(0, 1));
      row.field_bits = 6'($urandom_range(0, 63));
    end else begin
      load_pct = (held_count < 16) ? 75 : (held_count > 48) ? 25 : 50;
      row.kind = ($urandom_range(0, 99) < load_pct) ? KIND_LOAD : KIND_READ;
      roll = $urandom_range(0, 99);
      if (roll < 4) row.field_bits = 6'd0;
      else if (roll < 8) row.field_bits = 6'($urandom_range(33, 63));
      else if (roll < 22) row.field_bits = 6'($urandom_range(24, 32));
      else row.field_bits = 6'($urandom_range(1, 16));
    end
    return row;
  endfunction

  // Drive one input beat in bursts, hold it until accepted, then record the result due
  task automatic send_beat(input stim_row_t row);
    int unsigned   gap;
    field_result_t due;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left = burst_left - 1;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= row.kind;
    in_tdata  <= {1'b0, row.first_high, row.field_bits, row.byte_in};
    do @(posedge clk); while (!in_tready);
    due = step_bit_queue(row);
    if (row.typed) begin
      due.value  = row.value;
      due.status = row.status;
      due.held   = row.held;
    end
    field_results_due.push_back(due);
  endtask

  // Stall the result channel in modes of its own, each picked at random
  int unsigned ready_mode = 0;
  int unsigned mode_left  = 0;
  always @(negedge clk) begin
    if (mode_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      mode_left  = 50;
    end
    mode_left = mode_left - 1;
    case (ready_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= ($urandom_range(0, 4) == 0);
      default: out_tready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // Compare each result beat with the oldest one due
  always @(posedge clk) begin
    field_result_t due;
    if (rst_n && out_tvalid && out_tready) begin
      if (field_results_due.size() == 0) begin
        mismatches = mismatches + 1;
        $display("%0t: unexpected result beat, actual data %h", $time, out_tdata);
      end else begin
        due = field_results_due.pop_front();
        if (out_tdata[31:0] !== due.value) begin
          mismatches = mismatches + 1;
          $display("%0t: value expected %h actual %h", $time, due.value, out_tdata[31:0]);
        end
        if (out_tdata[33:32] !== due.status) begin
          mismatches = mismatches + 1;
          $display("%0t: status expected %0d actual %0d", $time, due.status,
                   out_tdata[33:32]);
        end
        if (out_tdata[40:34] !== due.held) begin
          mismatches = mismatches + 1;
          $display("%0t: bits_held expected %0d actual %0d", $time, due.held,
                   out_tdata[40:34]);
        end
      end
    end
  end

  // End the run as failed once the cycle count reaches CYCLE_LIMIT
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_lsb_first_bit_field_reader failed");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) send_beat(directed_rows[i]);
    repeat (RANDOM_BEATS) send_beat(random_row());

    @(negedge clk);
    in_tvalid <= 1'b0;

    // Drain outstanding results, then watch for stray beats
    while (field_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && field_results_due.size() == 0) begin
      $display("tb_lsb_first_bit_field_reader passed");
    end else begin
      $display("tb_lsb_first_bit_field_reader failed");
    end
    $finish;
  end

endmodule

// ===== lsb_first_bit_field_reader.f =====
rtl/core/lsbfr_pkg.sv
rtl/core/lsb_first_bit_field_reader.sv
sim/tb_lsb_first_bit_field_reader.sv
